@@ rtl/line_pair_closest_midpoint_core_assert.svh @@
`ifndef LINE_PAIR_CLOSEST_MIDPOINT_CORE_ASSERT_SVH
`define LINE_PAIR_CLOSEST_MIDPOINT_CORE_ASSERT_SVH
// assertion macros for the port level checker
// property checked outside reset
`define LPCM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// property checked during reset as well
`define LPCM_ASSERT_RAW(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`endif

@@ rtl/lpcm_pkg.sv @@
// widths, constants and types for the line pair midpoint core
`timescale 1ns / 1ps
package lpcm_pkg;

    localparam int COORD_W         = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int DIF_W           = COORD_W + 1;
    localparam int DOT_W           = 2 * DIF_W + 2;
    localparam int DET_W           = 2 * DOT_W;
    localparam int NUM_W           = DET_W + DIF_W + 7;
    localparam int REM_W           = NUM_W + 2;
    localparam int Q_W             = COORD_W;
    localparam int LIMIT_W         = 63;
    localparam int LIMIT_FRAC_BITS = 64;
    localparam int CMP_W           = DET_W + 64;

    localparam int DD_SHL  = (LIMIT_FRAC_BITS >= 4 * COORD_FRAC_BITS) ?
                             LIMIT_FRAC_BITS - 4 * COORD_FRAC_BITS : 0;
    localparam int LIM_SHL = (LIMIT_FRAC_BITS >= 4 * COORD_FRAC_BITS) ?
                             0 : 4 * COORD_FRAC_BITS - LIMIT_FRAC_BITS;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 63'd18446744074;
    localparam logic [COORD_W-1:0] COORD_MAX   = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN   = 32'h8000_0000;

    // limb multiplier
    localparam int MUL_AW  = DET_W + 4;
    localparam int MUL_BW  = DOT_W + 2;
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int LIMB_W  = 32;
    localparam int MUL_AL  = (MUL_AW + LIMB_W - 1) / LIMB_W;
    localparam int MUL_BL  = (MUL_BW + LIMB_W - 1) / LIMB_W;
    localparam int MUL_DG  = MUL_AL + MUL_BL - 1;
    localparam int MUL_LAT = 7;

    typedef struct packed {
        logic [2:0][DIF_W-1:0] u;
        logic [2:0][DIF_W-1:0] v;
        logic [2:0][DIF_W-1:0] w;
        logic [2:0][DIF_W-1:0] s;
    } geo_t;

    typedef struct packed {
        logic [DOT_W-1:0] b;
        logic [DOT_W-1:0] c;
        logic [DOT_W-1:0] d;
        logic [DOT_W-1:0] e;
    } bcde_t;

    typedef struct packed {
        logic             par;
        logic             dz;
        logic [DET_W-1:0] den;
    } side_t;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } div_t;

endpackage

@@ rtl/line_pair_closest_midpoint_core.sv @@
// top level: midpoint of the closest points between two 3d lines
// usage
//   s_ channel: one transfer carries two lines, each as two points in signed
//   q16.16; m_ channel: one transfer per input with the midpoint (saturated)
//   and the parallel and zero divisor flags. cfg_we/cfg_wdata set the
//   parallel limit on the determinant, in units of 2^-64.
//   throughput: one item per cycle while no result is stuck at the output;
//   every unit is fully pipelined. the path runs through three ranks of
//   7-stage limb multipliers (dot products, determinant terms, numerators)
//   and the 32-step restoring divider, one quotient bit a stage.
//   reset clears all valid bits and returns the limit to about 1e-9.
//   when the output holds a result and m_ready is low the whole pipeline
//   freezes and s_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module line_pair_closest_midpoint_core import lpcm_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [LIMIT_W-1:0]        cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_first_a_x,
    input  logic signed [COORD_W-1:0] s_first_a_y,
    input  logic signed [COORD_W-1:0] s_first_a_z,
    input  logic signed [COORD_W-1:0] s_first_b_x,
    input  logic signed [COORD_W-1:0] s_first_b_y,
    input  logic signed [COORD_W-1:0] s_first_b_z,
    input  logic signed [COORD_W-1:0] s_second_a_x,
    input  logic signed [COORD_W-1:0] s_second_a_y,
    input  logic signed [COORD_W-1:0] s_second_a_z,
    input  logic signed [COORD_W-1:0] s_second_b_x,
    input  logic signed [COORD_W-1:0] s_second_b_y,
    input  logic signed [COORD_W-1:0] s_second_b_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_mid_x,
    output logic signed [COORD_W-1:0] m_mid_y,
    output logic signed [COORD_W-1:0] m_mid_z,
    output logic                      m_parallel_case,
    output logic                      m_divisor_zero
);

    // stage map, each index is one register level
    localparam int ST_GEO   = 1;                  // differences and sums
    localparam int ST_DOTP  = ST_GEO + MUL_LAT;   // dot product terms
    localparam int ST_ABC   = ST_DOTP + 1;        // a, b, c, d, e
    localparam int ST_DETP  = ST_ABC + MUL_LAT;   // determinant terms
    localparam int ST_DET   = ST_DETP + 1;        // D and both numerators
    localparam int ST_SEL   = ST_DET + 1;         // branch and divisor choice
    localparam int ST_NUMP  = ST_SEL + MUL_LAT;   // numerator terms
    localparam int ST_T1    = ST_NUMP + 1;
    localparam int ST_NUM   = ST_T1 + 1;
    localparam int ST_MAG   = ST_NUM + 1;
    localparam int ST_TOT   = ST_MAG + 1;
    localparam int ST_DIV0  = ST_TOT + 1;         // overflow check
    localparam int ST_DIVN  = ST_DIV0 + Q_W;      // last quotient bit
    localparam int ST_OUT   = ST_DIVN + 1;

    logic               ce;
    logic [ST_OUT:1]    vld_reg;
    logic [LIMIT_W-1:0] lim_reg;

    // one enable for the whole pipe: it moves unless a result is stuck
    assign ce      = !vld_reg[ST_OUT] || m_ready;
    assign s_ready = ce;
    assign m_valid = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[ST_OUT-1:1], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            lim_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------- geometry
    logic signed [COORD_W-1:0] pa1 [3];
    logic signed [COORD_W-1:0] pb1 [3];
    logic signed [COORD_W-1:0] pa2 [3];
    logic signed [COORD_W-1:0] pb2 [3];
    geo_t geo_next;
    geo_t geo_reg [ST_GEO:ST_SEL];

    always_comb begin
        pa1[0] = s_first_a_x;  pa1[1] = s_first_a_y;  pa1[2] = s_first_a_z;
        pb1[0] = s_first_b_x;  pb1[1] = s_first_b_y;  pb1[2] = s_first_b_z;
        pa2[0] = s_second_a_x; pa2[1] = s_second_a_y; pa2[2] = s_second_a_z;
        pb2[0] = s_second_b_x; pb2[1] = s_second_b_y; pb2[2] = s_second_b_z;
        for (int k = 0; k < 3; k++) begin
            geo_next.u[k] = DIF_W'(pb1[k]) - DIF_W'(pa1[k]);
            geo_next.v[k] = DIF_W'(pb2[k]) - DIF_W'(pa2[k]);
            geo_next.w[k] = DIF_W'(pa1[k]) - DIF_W'(pa2[k]);
            geo_next.s[k] = DIF_W'(pa1[k]) + DIF_W'(pa2[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            geo_reg[ST_GEO] <= geo_next;
            for (int i = ST_GEO + 1; i <= ST_SEL; i++) begin
                geo_reg[i] <= geo_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------ dot products
    // order: a = u.u, b = u.v, c = v.v, d = u.w, e = v.w
    logic signed [DIF_W-1:0]  dl_op [5][3];
    logic signed [DIF_W-1:0]  dr_op [5][3];
    logic signed [MUL_PW-1:0] pr_dot [5][3];
    logic signed [DOT_W-1:0]  dot_reg [5];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dl_op[0][k] = $signed(geo_reg[ST_GEO].u[k]);
            dr_op[0][k] = $signed(geo_reg[ST_GEO].u[k]);
            dl_op[1][k] = $signed(geo_reg[ST_GEO].u[k]);
            dr_op[1][k] = $signed(geo_reg[ST_GEO].v[k]);
            dl_op[2][k] = $signed(geo_reg[ST_GEO].v[k]);
            dr_op[2][k] = $signed(geo_reg[ST_GEO].v[k]);
            dl_op[3][k] = $signed(geo_reg[ST_GEO].u[k]);
            dr_op[3][k] = $signed(geo_reg[ST_GEO].w[k]);
            dl_op[4][k] = $signed(geo_reg[ST_GEO].v[k]);
            dr_op[4][k] = $signed(geo_reg[ST_GEO].w[k]);
        end
    end

    for (genvar j = 0; j < 5; j++) begin : g_dot
        for (genvar k = 0; k < 3; k++) begin : g_axis
            lpcm_mul u_mul (
                .aclk (aclk),
                .ce   (ce),
                .a    (MUL_AW'(dl_op[j][k])),
                .b    (MUL_BW'(dr_op[j][k])),
                .p    (pr_dot[j][k])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int j = 0; j < 5; j++) begin
                dot_reg[j] <= DOT_W'(pr_dot[j][0]) + DOT_W'(pr_dot[j][1])
                            + DOT_W'(pr_dot[j][2]);
            end
        end
    end

    // b, c, d, e wait for the determinant terms
    bcde_t bcde_next;
    bcde_t dly_reg [ST_ABC+1:ST_DET];

    assign bcde_next = '{b: dot_reg[1], c: dot_reg[2], d: dot_reg[3], e: dot_reg[4]};

    always_ff @(posedge aclk) begin
        if (ce) begin
            dly_reg[ST_ABC+1] <= bcde_next;
            for (int i = ST_ABC + 2; i <= ST_DET; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------- determinant terms
    // pairs: a*c, b*b, b*e, c*d, a*e, b*d
    logic signed [DOT_W-1:0]  el_op [6];
    logic signed [DOT_W-1:0]  er_op [6];
    logic signed [MUL_PW-1:0] pr_det [6];
    logic signed [DET_W-1:0]  dd_reg;
    logic signed [DET_W-1:0]  ns_reg;
    logic signed [DET_W-1:0]  nt_reg;

    always_comb begin
        el_op[0] = dot_reg[0]; er_op[0] = dot_reg[2];
        el_op[1] = dot_reg[1]; er_op[1] = dot_reg[1];
        el_op[2] = dot_reg[1]; er_op[2] = dot_reg[4];
        el_op[3] = dot_reg[2]; er_op[3] = dot_reg[3];
        el_op[4] = dot_reg[0]; er_op[4] = dot_reg[4];
        el_op[5] = dot_reg[1]; er_op[5] = dot_reg[3];
    end

    for (genvar j = 0; j < 6; j++) begin : g_det
        lpcm_mul u_mul (
            .aclk (aclk),
            .ce   (ce),
            .a    (MUL_AW'(el_op[j])),
            .b    (MUL_BW'(er_op[j])),
            .p    (pr_det[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dd_reg <= DET_W'(pr_det[0]) - DET_W'(pr_det[1]);
            ns_reg <= DET_W'(pr_det[2]) - DET_W'(pr_det[3]);
            nt_reg <= DET_W'(pr_det[4]) - DET_W'(pr_det[5]);
        end
    end

    // -------------------------------------------------------- branch selection
    // every branch is folded into num = s*den + n1*u + n2*v over 2*den
    logic [CMP_W-1:0]        dd_cmp;
    logic [CMP_W-1:0]        lim_cmp;
    logic                    par;
    side_t                   side_next;
    logic signed [DET_W-1:0] n1_next;
    logic signed [DET_W-1:0] n2_next;
    side_t                   side_reg [ST_SEL:ST_DIVN];
    logic signed [DET_W-1:0] n1_reg;
    logic signed [DET_W-1:0] n2_reg;

    always_comb begin
        dd_cmp    = CMP_W'($unsigned(dd_reg)) << DD_SHL;
        lim_cmp   = CMP_W'(lim_reg) << LIM_SHL;
        // a negative determinant is below any limit
        par       = dd_reg[DET_W-1] || (dd_cmp < lim_cmp);
        side_next = '{par: par, dz: 1'b0, den: {{(DET_W-1){1'b0}}, 1'b1}};
        n1_next   = '0;
        n2_next   = '0;
        priority if (par) begin
            priority if ($signed(dly_reg[ST_DET].b) > $signed(dly_reg[ST_DET].c)) begin
                side_next.den = DET_W'($signed(dly_reg[ST_DET].b));
                n2_next       = DET_W'($signed(dly_reg[ST_DET].d));
            end else if (dly_reg[ST_DET].c != '0) begin
                side_next.den = DET_W'($signed(dly_reg[ST_DET].c));
                n2_next       = DET_W'($signed(dly_reg[ST_DET].e));
            end else begin
                side_next.dz  = 1'b1;
            end
        end else if (dd_reg[DET_W-1] || dd_reg == '0) begin
            side_next.dz = 1'b1;
        end else begin
            side_next.den = $unsigned(dd_reg);
            n1_next       = ns_reg;
            n2_next       = nt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg[ST_SEL] <= side_next;
            n1_reg           <= n1_next;
            n2_reg           <= n2_next;
            for (int i = ST_SEL + 1; i <= ST_DIVN; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------- numerator terms
    logic signed [MUL_PW-1:0] pr_sd [3];
    logic signed [MUL_PW-1:0] pr_n1 [3];
    logic signed [MUL_PW-1:0] pr_n2 [3];
    logic signed [NUM_W-1:0]  t_reg [3];
    logic signed [NUM_W-1:0]  p2_reg [3];
    logic signed [NUM_W-1:0]  num_reg [3];
    logic [NUM_W-1:0]         mag_reg [3];
    logic                     mag_neg_reg [3];
    logic [REM_W-1:0]         tot_reg [3];
    logic                     tot_neg_reg [3];

    for (genvar k = 0; k < 3; k++) begin : g_num
        lpcm_mul u_mul_sd (
            .aclk (aclk),
            .ce   (ce),
            .a    (MUL_AW'(side_reg[ST_SEL].den)),
            .b    (MUL_BW'($signed(geo_reg[ST_SEL].s[k]))),
            .p    (pr_sd[k])
        );
        lpcm_mul u_mul_n1 (
            .aclk (aclk),
            .ce   (ce),
            .a    (MUL_AW'(n1_reg)),
            .b    (MUL_BW'($signed(geo_reg[ST_SEL].u[k]))),
            .p    (pr_n1[k])
        );
        lpcm_mul u_mul_n2 (
            .aclk (aclk),
            .ce   (ce),
            .a    (MUL_AW'(n2_reg)),
            .b    (MUL_BW'($signed(geo_reg[ST_SEL].v[k]))),
            .p    (pr_n2[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                t_reg[k]       <= NUM_W'(pr_sd[k]) + NUM_W'(pr_n1[k]);
                p2_reg[k]      <= NUM_W'(pr_n2[k]);
                num_reg[k]     <= t_reg[k] + p2_reg[k];
                mag_neg_reg[k] <= num_reg[k][NUM_W-1];
                mag_reg[k]     <= num_reg[k][NUM_W-1] ? NUM_W'(-num_reg[k])
                                                      : NUM_W'(num_reg[k]);
                // rounding bias: floor((|num| + den) / (2 den))
                tot_reg[k]     <= REM_W'(mag_reg[k]) + REM_W'(side_reg[ST_MAG].den);
                tot_neg_reg[k] <= mag_neg_reg[k];
            end
        end
    end

    // ------------------------------------------------------ restoring divider
    div_t dv_reg [ST_DIV0:ST_DIVN][3];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                dv_reg[ST_DIV0][k].neg <= tot_neg_reg[k];
                // quotient would need more than 32 bits: saturate
                dv_reg[ST_DIV0][k].ovf <= tot_reg[k]
                                          >= (REM_W'(side_reg[ST_TOT].den) << (Q_W + 1));
                dv_reg[ST_DIV0][k].rem <= tot_reg[k];
                dv_reg[ST_DIV0][k].q   <= '0;
            end
        end
    end

    for (genvar s = ST_DIV0 + 1; s <= ST_DIVN; s++) begin : g_step
        localparam int BIT = ST_DIVN - s;
        for (genvar k = 0; k < 3; k++) begin : g_lane
            logic [REM_W-1:0] den_shift;
            div_t             step_next;

            always_comb begin
                den_shift = REM_W'(side_reg[s-1].den) << (BIT + 1);
                step_next = dv_reg[s-1][k];
                if (dv_reg[s-1][k].rem >= den_shift) begin
                    step_next.rem    = dv_reg[s-1][k].rem - den_shift;
                    step_next.q[BIT] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    dv_reg[s][k] <= step_next;
                end
            end
        end
    end

    // ------------------------------------------------------ sign and saturate
    logic [COORD_W-1:0] mid_next [3];
    logic [COORD_W-1:0] mid_reg [3];
    logic               par_reg;
    logic               dz_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            priority if (dv_reg[ST_DIVN][k].ovf) begin
                mid_next[k] = dv_reg[ST_DIVN][k].neg ? COORD_MIN : COORD_MAX;
            end else if (!dv_reg[ST_DIVN][k].neg) begin
                mid_next[k] = (dv_reg[ST_DIVN][k].q > COORD_MAX) ? COORD_MAX
                                                                : dv_reg[ST_DIVN][k].q;
            end else begin
                mid_next[k] = (dv_reg[ST_DIVN][k].q > COORD_MIN) ? COORD_MIN
                                                                : -dv_reg[ST_DIVN][k].q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mid_reg <= mid_next;
            par_reg <= side_reg[ST_DIVN].par;
            dz_reg  <= side_reg[ST_DIVN].dz;
        end
    end

    assign m_mid_x         = $signed(mid_reg[0]);
    assign m_mid_y         = $signed(mid_reg[1]);
    assign m_mid_z         = $signed(mid_reg[2]);
    assign m_parallel_case = par_reg;
    assign m_divisor_zero  = dz_reg;

endmodule

@@ rtl/lpcm_mul.sv @@
// pipelined signed limb multiplier, sign and magnitude form
`timescale 1ns / 1ps
module lpcm_mul import lpcm_pkg::*; (
    input  logic                     aclk,
    input  logic                     ce,
    input  logic signed [MUL_AW-1:0] a,
    input  logic signed [MUL_BW-1:0] b,
    output logic signed [MUL_PW-1:0] p
);

    localparam int A_PAD = MUL_AL * LIMB_W;
    localparam int B_PAD = MUL_BL * LIMB_W;
    localparam int PP_W  = 2 * LIMB_W;
    localparam int DG_W  = PP_W + 2;
    localparam int QN    = (MUL_DG + 1) / 2;

    logic [A_PAD-1:0]  am_reg;
    logic [B_PAD-1:0]  bm_reg;
    logic [6:1]        neg_reg;
    logic [PP_W-1:0]   pp_reg [MUL_AL][MUL_BL];
    logic [DG_W-1:0]   dg_reg [MUL_DG];
    logic [DG_W-1:0]   dg_next [MUL_DG];
    logic [MUL_PW-1:0] q_reg [QN];
    logic [MUL_PW-1:0] h_reg [2];
    logic [MUL_PW-1:0] mag_reg;
    logic signed [MUL_PW-1:0] p_reg;
    logic [MUL_AW-1:0] a_mag;
    logic [MUL_BW-1:0] b_mag;

    assign a_mag = a[MUL_AW-1] ? MUL_AW'(-a) : MUL_AW'(a);
    assign b_mag = b[MUL_BW-1] ? MUL_BW'(-b) : MUL_BW'(b);

    always_comb begin
        for (int k = 0; k < MUL_DG; k++) begin
            dg_next[k] = '0;
        end
        for (int i = 0; i < MUL_AL; i++) begin
            for (int j = 0; j < MUL_BL; j++) begin
                dg_next[i+j] = dg_next[i+j] + DG_W'(pp_reg[i][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            am_reg     <= A_PAD'(a_mag);
            bm_reg     <= B_PAD'(b_mag);
            neg_reg[1] <= a[MUL_AW-1] ^ b[MUL_BW-1];
            for (int n = 2; n <= 6; n++) begin
                neg_reg[n] <= neg_reg[n-1];
            end
            for (int i = 0; i < MUL_AL; i++) begin
                for (int j = 0; j < MUL_BL; j++) begin
                    pp_reg[i][j] <= PP_W'(am_reg[i*LIMB_W +: LIMB_W])
                                  * PP_W'(bm_reg[j*LIMB_W +: LIMB_W]);
                end
            end
            dg_reg <= dg_next;
            for (int m = 0; m < QN; m++) begin
                if (2 * m + 1 < MUL_DG) begin
                    q_reg[m] <= MUL_PW'(dg_reg[2*m])
                              + (MUL_PW'(dg_reg[2*m+1]) << LIMB_W);
                end else begin
                    q_reg[m] <= MUL_PW'(dg_reg[2*m]);
                end
            end
            h_reg[0] <= q_reg[0] + (q_reg[1] << (2 * LIMB_W));
            h_reg[1] <= q_reg[2] + (q_reg[3] << (2 * LIMB_W));
            mag_reg  <= h_reg[0] + (h_reg[1] << (4 * LIMB_W));
            p_reg    <= neg_reg[6] ? -$signed(mag_reg) : $signed(mag_reg);
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/lpcm_checker.sv @@
// port level checker for the line pair midpoint core, with its bind
`timescale 1ns / 1ps
`include "line_pair_closest_midpoint_core_assert.svh"
module lpcm_checker import lpcm_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [COORD_W-1:0] m_mid_x,
    input logic signed [COORD_W-1:0] m_mid_y,
    input logic signed [COORD_W-1:0] m_mid_z,
    input logic                      m_parallel_case,
    input logic                      m_divisor_zero
);

    logic [3*COORD_W+1:0] m_payload;

    assign m_payload = {m_mid_x, m_mid_y, m_mid_z, m_parallel_case, m_divisor_zero};

    // a stalled result holds until its transfer
    `LPCM_ASSERT_RST(a_out_hold, (m_valid && !m_ready) |=> m_valid, "stalled result dropped")

    `LPCM_ASSERT_RST(a_data_hold, (m_valid && !m_ready) |=> $stable(m_payload), "stalled result moved")

    // input side only stalls behind a stuck result
    `LPCM_ASSERT_RST(a_ready, (m_ready || !m_valid) |-> s_ready, "input stalled without output stall")

    // reset empties the pipeline
    `LPCM_ASSERT_RAW(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind line_pair_closest_midpoint_core lpcm_checker u_lpcm_checker (.*);

@@ verif/testbench.sv @@
// self-checking testbench for the line pair closest midpoint core
`timescale 1ns / 1ps
module testbench;
    import lpcm_pkg::*;

    // wide signed arithmetic, wraps at 256 bits
    typedef logic signed [255:0] wide_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    // point order: a1 xyz, b1 xyz, a2 xyz, b2 xyz
    typedef coord_t pair_t [12];

    typedef struct packed {
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        logic signed [COORD_W-1:0] mz;
        logic                      par;
        logic                      dz;
    } mid_t;

    typedef struct {
        pair_t pts;
        logic  typed;  // expected result given in the row
        mid_t  res;
    } row_t;

    localparam int LATENCY     = 63;
    localparam int DRAIN_WAIT  = LATENCY + 10;
    localparam int WATCH_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_ROWS      = 10;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 115;

    localparam coord_t CMAX = COORD_MAX;
    localparam coord_t CMIN = COORD_MIN;
    localparam coord_t ONE  = 32'sd65536;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_pts [12];
    logic m_valid;
    logic m_ready = 1'b0;
    mid_t m_res;

    // testbench copy of the parallel limit
    logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;
    mid_t expected_mids [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int mismatches = 0;
    int quiet_cycles = 0;
    row_t rows [N_ROWS];

    initial begin
        for (int k = 0; k < 12; k++) s_pts[k] = '0;
    end

    line_pair_closest_midpoint_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_a_x    (s_pts[0]),
        .s_first_a_y    (s_pts[1]),
        .s_first_a_z    (s_pts[2]),
        .s_first_b_x    (s_pts[3]),
        .s_first_b_y    (s_pts[4]),
        .s_first_b_z    (s_pts[5]),
        .s_second_a_x   (s_pts[6]),
        .s_second_a_y   (s_pts[7]),
        .s_second_a_z   (s_pts[8]),
        .s_second_b_x   (s_pts[9]),
        .s_second_b_y   (s_pts[10]),
        .s_second_b_z   (s_pts[11]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mid_x        (m_res.mx),
        .m_mid_y        (m_res.my),
        .m_mid_z        (m_res.mz),
        .m_parallel_case(m_res.par),
        .m_divisor_zero (m_res.dz)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // round(num / (2*den)) ties away from zero, saturated to a coordinate
    function automatic coord_t round_to_coord(input wide_t num, input wide_t den);
        wide_t mag;
        wide_t q;
        mag = (num < 0) ? -num : num;
        q = (mag + den) / (den + den);
        if (num < 0) q = -q;
        if (q > wide_t'(CMAX)) return CMAX;
        if (q < wide_t'(CMIN)) return CMIN;
        return coord_t'(q[31:0]);
    endfunction

    // midpoint of the closest points, exact in wide integers
    function automatic mid_t closest_midpoint(input pair_t p, input logic [LIMIT_W-1:0] lim);
        wide_t u [3], v [3], w [3], s [3];
        wide_t a, b, c, d, e, det, lim_w, ns, nt, num, den;
        coord_t m [3];
        logic par, dz;
        mid_t r;
        a = 0; b = 0; c = 0; d = 0; e = 0;
        dz = 1'b0;
        for (int k = 0; k < 3; k++) begin
            u[k] = wide_t'(p[3+k]) - wide_t'(p[k]);
            v[k] = wide_t'(p[9+k]) - wide_t'(p[6+k]);
            w[k] = wide_t'(p[k]) - wide_t'(p[6+k]);
            s[k] = wide_t'(p[k]) + wide_t'(p[6+k]);
            a += u[k] * u[k];
            b += u[k] * v[k];
            c += v[k] * v[k];
            d += u[k] * w[k];
            e += v[k] * w[k];
        end
        det = a * c - b * b;
        lim_w = '0;
        lim_w[LIMIT_W-1:0] = lim;
        par = (det <<< DD_SHL) < (lim_w <<< LIM_SHL);
        ns = b * e - c * d;
        nt = a * e - b * d;
        for (int k = 0; k < 3; k++) begin
            if (par) begin
                if (b > c) begin
                    den = b;
                    num = s[k] * b + d * v[k];
                end else if (c != 0) begin
                    den = c;
                    num = s[k] * c + e * v[k];
                end else begin
                    dz = 1'b1;
                    den = 1;
                    num = s[k];
                end
            end else if (det <= 0) begin
                dz = 1'b1;
                den = 1;
                num = s[k];
            end else begin
                den = det;
                num = s[k] * det + ns * u[k] + nt * v[k];
            end
            m[k] = round_to_coord(num, den);
        end
        r.mx = m[0];
        r.my = m[1];
        r.mz = m[2];
        r.par = par;
        r.dz = dz;
        return r;
    endfunction

    function automatic coord_t rand_small(input int span);
        return coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic coord_t rand_corner();
        case ($urandom_range(5))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            3: return -1;
            4: return 1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // random line pair, mostly shaped to reach the interesting branches
    function automatic pair_t random_pair();
        pair_t p;
        coord_t dir [3];
        int scale;
        int mode;
        mode = $urandom_range(6);
        for (int k = 0; k < 12; k++) p[k] = coord_t'($urandom);
        for (int k = 0; k < 3; k++) dir[k] = rand_small(1 << 18);
        case (mode)
            1: for (int k = 0; k < 12; k++) p[k] = rand_small(1 << 22);
            2, 3: begin
                // parallel directions, one a scaled copy of the other
                scale = $urandom_range(0, 6) - 3;
                for (int k = 0; k < 3; k++) begin
                    p[k] = rand_small(1 << 24);
                    p[3+k] = p[k] + dir[k];
                    p[6+k] = rand_small(1 << 24);
                    p[9+k] = p[6+k] + ((mode == 2) ? dir[k] * scale : dir[k] >>> 2);
                end
            end
            4: begin
                // degenerate: each axis loses its extent on one line; sometimes both lines collapse to a point
                for (int k = 0; k < 3; k++) begin
                    if ($urandom_range(1)) p[3+k] = p[k];
                    else p[9+k] = p[6+k];
                end
                if ($urandom_range(3) == 0)
                    for (int k = 0; k < 3; k++) begin
                        p[3+k] = p[k];
                        p[9+k] = p[6+k];
                    end
            end
            5: begin
                // nearly parallel and far out, drives saturation
                for (int k = 0; k < 3; k++) begin
                    p[k] = rand_small(1 << 28);
                    p[3+k] = p[k] + dir[k];
                    p[6+k] = rand_small(1 << 28);
                    p[9+k] = p[6+k] + dir[k] + rand_small(2);
                end
            end
            6: for (int k = 0; k < 12; k++) p[k] = rand_corner();
            default: ;
        endcase
        return p;
    endfunction

    // one transfer on the input channel, expectation queued on acceptance
    task automatic offer_pair(input pair_t p, input logic typed, input mid_t res);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        for (int k = 0; k < 12; k++) s_pts[k] <= p[k];
        do @(posedge aclk); while (!s_ready);
        expected_mids.push_back(typed ? res : closest_midpoint(p, limit_now));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_mids.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        limit_now = value;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int held;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                held = 1;
                while (held < HOLD_CYCLES) begin
                    @(negedge aclk);
                    held++;
                end
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        mid_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_mids.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", m_res);
            end else begin
                want = expected_mids.pop_front();
                if (m_res !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mid mismatch: expected %0d %0d %0d par %b dz %b,",
                                  " got %0d %0d %0d par %b dz %b"},
                                 want.mx, want.my, want.mz, want.par, want.dz,
                                 m_res.mx, m_res.my, m_res.mz, m_res.par, m_res.dz);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCH_LIMIT) begin
                $display("line_pair_closest_midpoint_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [LIMIT_W-1:0] limits [N_PHASES];
        mid_t none;
        none = '0;
        // directed rows; typed results are the degenerate and obvious cases
        rows[0] = '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b1, 1'b1}};
        rows[1] = '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX},
                    1'b1, '{CMAX, CMAX, CMAX, 1'b1, 1'b1}};
        rows[2] = '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN},
                    1'b1, '{CMIN, CMIN, CMIN, 1'b1, 1'b1}};
        // sum of -1 halves to a tie, rounds away from zero
        rows[3] = '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX},
                    1'b1, '{-1, -1, -1, 1'b1, 1'b1}};
        // crossing axes one unit apart in z
        rows[4] = '{'{0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0, ONE, ONE},
                    1'b1, '{0, 0, ONE / 2, 1'b0, 1'b0}};
        // parallel, longer first line: b above c
        rows[5] = '{'{0, 0, 0, 2 * ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0}, 1'b0, none};
        // parallel, longer second line: c chosen
        rows[6] = '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 3 * ONE, ONE, 0}, 1'b0, none};
        // second line a point only
        rows[7] = '{'{0, 0, 0, ONE, ONE, 0, 5, 7, 9, 5, 7, 9}, 1'b0, none};
        // full range spread, saturates
        rows[8] = '{'{CMIN, CMAX, 0, CMAX, CMIN, -1, CMAX, CMAX, CMIN, CMIN, 1, CMAX}, 1'b0, none};
        rows[9] = '{'{CMAX, 0, CMIN, CMAX, 1, CMIN, CMIN, 0, CMAX, CMIN, -1, CMAX}, 1'b0, none};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) offer_pair(rows[r].pts, rows[r].typed, rows[r].res);
        wait_drained();

        limits[0] = LIMIT_RESET;
        limits[1] = '0;
        limits[2] = '1;
        limits[3] = LIMIT_W'({$urandom, $urandom});
        limits[4] = 63'd1 << $urandom_range(40, 62);
        limits[5] = LIMIT_RESET;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_limit(limits[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            // long receiver hold-off with the sender going flat out
            if (ph == 0) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) offer_pair(random_pair(), 1'b0, none);
            wait_drained();
        end

        if (mismatches == 0 && expected_mids.size() == 0) begin
            $display("line_pair_closest_midpoint_core regression: pass");
        end else begin
            $display("line_pair_closest_midpoint_core regression: fail");
        end
        $finish;
    end

endmodule
